FILE: hdl/owtr_pkg.sv
// owtr_pkg: shared constants, register indexes and the tenths scaling function
// for the one-wire temperature reader core.
// No dependencies.
package owtr_pkg;

    // default width of the phase tick counter
    localparam int unsigned COUNTER_WIDTH_DEF = 32;

    // configuration port widths
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    // stream payload widths
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 40;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_RELEASE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_LONG     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_SHORT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_DELAY  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CONV_WAIT     = 3'd5;

    // configuration reset values
    localparam logic [15:0] RESET_LOW_DEF     = 16'd480;
    localparam logic [15:0] RESET_RELEASE_DEF = 16'd60;
    localparam logic [15:0] SLOT_LONG_DEF     = 16'd60;
    localparam logic [7:0]  SLOT_SHORT_DEF    = 8'd2;
    localparam logic [7:0]  SAMPLE_DELAY_DEF  = 8'd2;
    localparam logic [31:0] CONV_WAIT_DEF     = 32'd0;

    // one-wire command bytes
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;

    // raw sensor word (1/16 degree) to tenths, rounded: (raw*10 + 8) >> 4
    function automatic logic [15:0] raw_to_tenths(input logic [15:0] raw);
        logic [19:0] scaled;
        scaled = {1'b0, raw, 3'b000} + {3'b000, raw, 1'b0} + 20'd8;
        return scaled[19:4];
    endfunction

endpackage

FILE: hdl/onewire_temperature_reader_core.sv
// onewire_temperature_reader_core: one-wire bus master that reads a 12-bit
// temperature sensor, stepped one bus tick per input item.
// Depends on owtr_pkg.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata: [0] start_req, [1] bus_level
//  m_        out  m_tvalid/m_tready    m_tdata: drive_low, busy_res, result_valid,
//                                      raw_reading, temp_tenths
//  cfg_      in   cfg_valid/cfg_ready  cfg_index (register), cfg_data
//
// Every tick item gives exactly one result item; the sequencer state and the
// result register update on the cycle the tick is taken, so a tick can be
// taken every cycle while results are read. The output register frees up the
// input side: a new tick is taken whenever the result register is empty or is
// being read out. Reset is synchronous on aresetn low and puts the sequencer in
// idle with the default timing registers. Configuration writes are always taken.
module onewire_temperature_reader_core
    import owtr_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // tick input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [0] start_req, [1] bus_level, rest zero
    // result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [0] drive_low, [1] busy_res,
                                              // [2] result_valid, [18:3] raw_reading,
                                              // [34:19] temp_tenths, rest zero
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // bus phase codes
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_RST_LOW = 4'd1;
    localparam logic [3:0] PH_RST_REL = 4'd2;
    localparam logic [3:0] PH_WR_LOW  = 4'd3;
    localparam logic [3:0] PH_WR_REL  = 4'd4;
    localparam logic [3:0] PH_CONV    = 4'd5;
    localparam logic [3:0] PH_RD_LOW  = 4'd6;
    localparam logic [3:0] PH_RD_REL  = 4'd7;
    localparam logic [3:0] PH_RD_REC  = 4'd8;

    // sequence step codes
    localparam logic [3:0] ST_RST1    = 4'd0;
    localparam logic [3:0] ST_CC1     = 4'd1;
    localparam logic [3:0] ST_CONVERT = 4'd2;
    localparam logic [3:0] ST_WAIT    = 4'd3;
    localparam logic [3:0] ST_RST2    = 4'd4;
    localparam logic [3:0] ST_CC2     = 4'd5;
    localparam logic [3:0] ST_READCMD = 4'd6;
    localparam logic [3:0] ST_RD0     = 4'd7;
    localparam logic [3:0] ST_RD1     = 4'd8;
    localparam logic [3:0] ST_END     = 4'd9;

    localparam logic [31:0] CMAX32 = 32'hFFFF_FFFF >> (32 - COUNTER_WIDTH);

    // timing registers
    logic [15:0] reset_low_reg, reset_release_reg, slot_long_reg;
    logic [7:0]  slot_short_reg, sample_delay_reg;
    logic [31:0] conv_wait_reg;

    // sequencer state
    logic [3:0]               phase_reg, phase_next;
    logic [3:0]               stage_reg, stage_next;
    logic [COUNTER_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [3:0]               bit_index_reg, bit_index_next;
    logic [7:0]               shift_byte_reg, shift_byte_next;
    logic [1:0]               byte_index_reg, byte_index_next;
    logic [7:0]               low_byte_reg, low_byte_next;
    logic [15:0]              raw_word_reg, raw_word_next;
    logic [15:0]              tenths_reg, tenths_next;

    // result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                     accept;
    logic                     start_req, bus_level;
    logic                     cur_bit;
    logic                     drive_low, busy_res, result_valid;
    logic [31:0]              dur32;
    logic [COUNTER_WIDTH-1:0] dur_sat;
    logic [COUNTER_WIDTH:0]   count_inc;
    logic                     tick_done;
    logic                     enter_req;
    logic [3:0]               enter_target;
    logic [3:0]               enter_eff;
    logic [3:0]               bit_index_inc;

    assign start_req = s_tdata[0];
    assign bus_level = s_tdata[1];
    assign cur_bit   = shift_byte_reg[0];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // outputs that reflect the state at the start of the tick
    assign drive_low = (phase_reg == PH_RST_LOW) || (phase_reg == PH_WR_LOW)
                    || (phase_reg == PH_RD_LOW);
    assign busy_res  = (phase_reg != PH_IDLE);

    // duration of the current phase
    always_comb begin
        case (phase_reg)
            PH_RST_LOW: dur32 = {16'd0, reset_low_reg};
            PH_RST_REL: dur32 = {16'd0, reset_release_reg};
            PH_WR_LOW:  dur32 = cur_bit ? {24'd0, slot_short_reg} : {16'd0, slot_long_reg};
            PH_WR_REL:  dur32 = cur_bit ? {16'd0, slot_long_reg} : {24'd0, slot_short_reg};
            PH_CONV:    dur32 = conv_wait_reg;
            PH_RD_LOW:  dur32 = {24'd0, slot_short_reg};
            PH_RD_REL:  dur32 = {24'd0, sample_delay_reg};
            PH_RD_REC:  dur32 = {16'd0, slot_long_reg};
            default:    dur32 = 32'd0;
        endcase
    end

    // saturate to the counter range and test for phase end
    assign dur_sat   = (dur32 > CMAX32) ? CMAX32[COUNTER_WIDTH-1:0]
                                        : dur32[COUNTER_WIDTH-1:0];
    assign count_inc = {1'b0, tick_count_reg} + {{COUNTER_WIDTH{1'b0}}, 1'b1};
    assign tick_done = (count_inc >= {1'b0, dur_sat});
    assign bit_index_inc = bit_index_reg + 4'd1;

    // sequencer next state
    always_comb begin
        phase_next      = phase_reg;
        stage_next      = stage_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        byte_index_next = byte_index_reg;
        low_byte_next   = low_byte_reg;
        raw_word_next   = raw_word_reg;
        tenths_next     = tenths_reg;
        result_valid    = 1'b0;
        enter_req       = 1'b0;
        enter_target    = ST_RST1;
        enter_eff       = ST_RST1;
        tick_count_next = tick_done ? '0 : count_inc[COUNTER_WIDTH-1:0];

        unique case (phase_reg)
            PH_IDLE: begin
                tick_count_next = tick_count_reg;
                if (start_req) begin
                    enter_req    = 1'b1;
                    enter_target = ST_RST1;
                end
            end
            PH_RST_LOW: begin
                if (tick_done) phase_next = PH_RST_REL;
            end
            PH_RST_REL: begin
                if (tick_done) begin
                    enter_req    = 1'b1;
                    enter_target = stage_reg + 4'd1;
                end
            end
            PH_WR_LOW: begin
                if (tick_done) phase_next = PH_WR_REL;
            end
            PH_WR_REL: begin
                if (tick_done) begin
                    shift_byte_next = {1'b0, shift_byte_reg[7:1]};
                    bit_index_next  = bit_index_inc;
                    if (bit_index_inc >= 4'd8) begin
                        enter_req    = 1'b1;
                        enter_target = stage_reg + 4'd1;
                    end else begin
                        phase_next = PH_WR_LOW;
                    end
                end
            end
            PH_CONV: begin
                if (tick_done) begin
                    enter_req    = 1'b1;
                    enter_target = ST_RST2;
                end
            end
            PH_RD_LOW: begin
                if (tick_done) phase_next = PH_RD_REL;
            end
            PH_RD_REL: begin
                if (tick_done) begin
                    shift_byte_next = {bus_level, shift_byte_reg[7:1]};
                    phase_next      = PH_RD_REC;
                end
            end
            PH_RD_REC: begin
                if (tick_done) begin
                    bit_index_next = bit_index_inc;
                    if (bit_index_inc < 4'd8) begin
                        phase_next = PH_RD_LOW;
                    end else if (byte_index_reg == 2'd0) begin
                        low_byte_next = shift_byte_reg;
                        enter_req     = 1'b1;
                        enter_target  = ST_RD1;
                    end else begin
                        raw_word_next = {shift_byte_reg, low_byte_reg};
                        tenths_next   = raw_to_tenths({shift_byte_reg, low_byte_reg});
                        result_valid  = 1'b1;
                        enter_req     = 1'b1;
                        enter_target  = ST_END;
                    end
                end
            end
            default: begin
                phase_next      = PH_IDLE;
                stage_next      = ST_RST1;
                tick_count_next = '0;
            end
        endcase

        // entering a sequence step: skip the wait when it is zero
        if (enter_req) begin
            enter_eff = ((enter_target == ST_WAIT) && (conv_wait_reg == 32'd0))
                      ? ST_RST2 : enter_target;
            stage_next      = enter_eff;
            tick_count_next = '0;
            bit_index_next  = 4'd0;
            case (enter_eff) inside
                ST_RST1, ST_RST2: phase_next = PH_RST_LOW;
                ST_CC1, ST_CC2: begin
                    shift_byte_next = CMD_SKIP_ROM;
                    phase_next      = PH_WR_LOW;
                end
                ST_CONVERT: begin
                    shift_byte_next = CMD_CONVERT;
                    phase_next      = PH_WR_LOW;
                end
                ST_READCMD: begin
                    shift_byte_next = CMD_READ_SCRPD;
                    phase_next      = PH_WR_LOW;
                end
                ST_WAIT: phase_next = PH_CONV;
                ST_RD0, ST_RD1: begin
                    shift_byte_next = 8'd0;
                    byte_index_next = (enter_eff == ST_RD1) ? 2'd1 : 2'd0;
                    phase_next      = PH_RD_LOW;
                end
                default: begin
                    phase_next = PH_IDLE;
                    stage_next = ST_RST1;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg     <= RESET_LOW_DEF;
            reset_release_reg <= RESET_RELEASE_DEF;
            slot_long_reg     <= SLOT_LONG_DEF;
            slot_short_reg    <= SLOT_SHORT_DEF;
            sample_delay_reg  <= SAMPLE_DELAY_DEF;
            conv_wait_reg     <= CONV_WAIT_DEF;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RESET_LOW:     reset_low_reg     <= cfg_data[15:0];
                REG_RESET_RELEASE: reset_release_reg <= cfg_data[15:0];
                REG_SLOT_LONG:     slot_long_reg     <= cfg_data[15:0];
                REG_SLOT_SHORT:    slot_short_reg    <= cfg_data[7:0];
                REG_SAMPLE_DELAY:  sample_delay_reg  <= cfg_data[7:0];
                REG_CONV_WAIT:     conv_wait_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            stage_reg      <= ST_RST1;
            tick_count_reg <= '0;
            bit_index_reg  <= 4'd0;
            shift_byte_reg <= 8'd0;
            byte_index_reg <= 2'd0;
            low_byte_reg   <= 8'd0;
            raw_word_reg   <= 16'd0;
            tenths_reg     <= 16'd0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            stage_reg      <= stage_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            byte_index_reg <= byte_index_next;
            low_byte_reg   <= low_byte_next;
            raw_word_reg   <= raw_word_next;
            tenths_reg     <= tenths_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {5'd0, tenths_next, raw_word_next, result_valid,
                            busy_res, drive_low};
        end
    end

endmodule
